FILE: rtl/core/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg
// Types and constants shared by the buffer admission table and its memory.
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

	typedef enum logic [2:0] {
		ACT_BIND       = 3'd0,
		ACT_UNTRACK    = 3'd1,
		ACT_SET_HASH   = 3'd2,
		ACT_SET_UNSUP  = 3'd3,
		ACT_LOOKUP     = 3'd4,
		ACT_PICK       = 3'd5,
		ACT_RESET_HASH = 3'd6,
		ACT_CLEAR      = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_INSERTED    = 3'd1,
		STS_NONE        = 3'd2,
		STS_SIZE_REJECT = 3'd3,
		STS_FULL        = 3'd4,
		STS_ZERO_HANDLE = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		HS_PENDING  = 2'd0,
		HS_LEARNING = 2'd1,
		HS_DONE     = 2'd2,
		HS_UNSUP    = 2'd3
	} hash_state_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_FLUSH
	} fsm_t;

	// configuration register indexes
	localparam logic [1:0] REG_MIN_WIDTH = 2'd0;
	localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
	localparam logic [1:0] REG_CAPACITY  = 2'd2;

	localparam logic [1:0]  KIND_INDEX        = 2'd1;
	localparam logic [39:0] LARGE_INDEX_BYTES = 40'd262144;
	localparam logic [6:0]  MAX_RESULTS       = 7'd64;
	localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

	// one table entry as held in the memory
	typedef struct packed {
		logic [63:0] handle;
		logic [39:0] width;
		logic [1:0]  kind;
		hash_state_t hstate;
		logic [31:0] chash;
		logic [31:0] lhash;
		logic [31:0] frame;
		logic [31:0] count;
	} rec_t;

	function automatic logic is_large(input rec_t r);
		return (r.kind == KIND_INDEX) && (r.width >= LARGE_INDEX_BYTES);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bat_mem.sv
// ----------------------------------------------------------------------------
// bat_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_mem #(
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output bat_pkg::rec_t           rd_data,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  bat_pkg::rec_t           wr_data
);
	import bat_pkg::*;

	rec_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/buffer_admission_table.sv
// Buffer admission table: entries live in one memory, walked by a scan.
// Each scan reads every slot once, then the table moves to a decide state.
// Bind, untrack, set hash, set unsupported, lookup and reset hashes take one
// scan; each eviction inside a bind adds one scan. Pick pending takes one scan
// per picked entry, then a flush state, or one more scan when pending entries
// run out first; zero handle, clear and an empty budget skip the scan.
// Reset empties the table (valid bits and count clear at once) and loads the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// buffer_admission_table
// Tracks buffers by handle with oldest-first eviction of pending or
// unsupported entries and ranked hand-out of pending entries.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_admission_table #(
	parameter int DEPTH = 64
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// key_handle, width_bytes, buffer_kind, frame_now, content_hash,
	// learned_hash, pick_budget, zero pad
	input  wire  [215:0] s_tdata,
	// action
	input  wire  [2:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// out_handle, out_width_bytes, out_kind, out_hash_state, out_content_hash,
	// out_learned_hash, out_frame_seen, out_bind_count, zero pad
	output logic [239:0] m_tdata,
	// status
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	input  wire          cfg_we,
	input  wire  [1:0]   cfg_index,
	input  wire  [39:0]  cfg_wdata
);
	import bat_pkg::*;

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam int CmpW = (CntW > 7) ? CntW : 7;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

	// configuration
	logic [39:0] min_q, max_q;
	logic [6:0]  cap_q;

	// command registers
	action_t     act_q;
	logic        zero_q;
	logic [63:0] key_q;
	logic [39:0] width_q;
	logic [1:0]  kind_q;
	logic [31:0] frame_q, chash_q, lhash_q;
	logic [6:0]  limit_q, n_q;

	fsm_t fsm_q, fsm_d;
	logic [DEPTH-1:0] valid_q;
	logic [CntW-1:0]  count_q;

	// scan pipeline
	logic [IdxW-1:0] rd_idx_q, idx_s1;
	logic            rd_done_q, vld_s1, rd_en;
	rec_t            rd_rec;

	// scan results
	logic            hit_q, free_found_q, vic_found_q, best_found_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q, vic_idx_q, best_idx_q;
	rec_t            hit_rec_q, best_rec_q;
	logic [31:0]     vic_frame_q;

	// pick hold
	logic held_v_q;
	rec_t held_q;

	// output register
	logic    out_valid_q, out_last_q;
	status_t out_st_q;
	rec_t    out_rec_q;

	// decide strobes
	logic            emit, emit_last, wr_en, vclr, vset, clr_all, cnt_inc, cnt_dec;
	logic            pick_adv, scan_start, accept, out_free;
	status_t         emit_st;
	rec_t            emit_rec, wr_rec, upd_rec;
	logic [IdxW-1:0] wr_addr, vclr_idx;

	action_t     in_act;
	logic [63:0] in_key;
	logic [6:0]  in_budget, in_limit;
	logic        in_zero, row_valid, size_bad, over_cap;

	assign in_act    = action_t'(s_tuser);
	assign in_key    = s_tdata[63:0];
	assign in_budget = s_tdata[208:202];
	assign in_limit  = (in_budget > MAX_RESULTS) ? MAX_RESULTS : in_budget;
	assign in_zero   = (in_act <= ACT_LOOKUP) && (in_key == 64'd0);

	assign s_tready = (fsm_q == FSM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign rd_en    = (fsm_q == FSM_SCAN) && !rd_done_q;
	assign row_valid = valid_q[idx_s1];
	assign size_bad = (width_q < min_q) || (width_q > max_q);
	assign over_cap = CmpW'(count_q) >= CmpW'(cap_q);

	bat_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_rec),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
			cap_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_WIDTH: min_q <= cfg_wdata;
				REG_MAX_WIDTH: max_q <= cfg_wdata;
				REG_CAPACITY:  cap_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	// next state and decide actions
	always_comb begin
		fsm_d     = fsm_q;
		emit      = 1'b0;
		emit_st   = STS_OK;
		emit_rec  = '0;
		emit_last = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = idx_s1;
		wr_rec    = rd_rec;
		vclr      = 1'b0;
		vclr_idx  = hit_idx_q;
		vset      = 1'b0;
		clr_all   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		pick_adv  = 1'b0;
		upd_rec   = hit_rec_q;
		case (fsm_q)
			FSM_IDLE: begin
				if (s_tvalid) begin
					if (in_zero || in_act == ACT_CLEAR || (in_act == ACT_PICK && in_limit == 7'd0))
						fsm_d = FSM_DECIDE;
					else
						fsm_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				// clear hashes of valid rows as they stream past
				if (vld_s1 && act_q == ACT_RESET_HASH && row_valid) begin
					wr_en         = 1'b1;
					wr_rec.hstate = HS_PENDING;
					wr_rec.chash  = '0;
					wr_rec.lhash  = '0;
				end
				if (vld_s1 && idx_s1 == LastIdx)
					fsm_d = FSM_DECIDE;
			end
			FSM_DECIDE: begin
				if (out_free) begin
					fsm_d = FSM_IDLE;
					if (zero_q) begin
						emit    = 1'b1;
						emit_st = STS_ZERO_HANDLE;
					end else begin
						case (act_q)
							ACT_BIND: begin
								if (hit_q) begin
									upd_rec.frame = frame_q;
									if (hit_rec_q.count != COUNT_MAX)
										upd_rec.count = hit_rec_q.count + 32'd1;
									wr_en    = 1'b1;
									wr_addr  = hit_idx_q;
									wr_rec   = upd_rec;
									emit     = 1'b1;
									emit_rec = upd_rec;
								end else if (size_bad) begin
									emit    = 1'b1;
									emit_st = STS_SIZE_REJECT;
								end else if (over_cap && vic_found_q) begin
									// drop the oldest evictable entry and rescan
									vclr     = 1'b1;
									vclr_idx = vic_idx_q;
									cnt_dec  = 1'b1;
									fsm_d    = FSM_SCAN;
								end else if (free_found_q) begin
									upd_rec = '{handle: key_q, width: width_q, kind: kind_q,
										hstate: HS_PENDING, chash: 32'd0, lhash: 32'd0,
										frame: frame_q, count: 32'd1};
									wr_en    = 1'b1;
									wr_addr  = free_idx_q;
									wr_rec   = upd_rec;
									vset     = 1'b1;
									cnt_inc  = 1'b1;
									emit     = 1'b1;
									emit_st  = STS_INSERTED;
									emit_rec = upd_rec;
								end else begin
									emit    = 1'b1;
									emit_st = STS_FULL;
								end
							end
							ACT_UNTRACK, ACT_SET_HASH, ACT_SET_UNSUP, ACT_LOOKUP: begin
								emit = 1'b1;
								if (!hit_q) begin
									emit_st = STS_NONE;
								end else begin
									if (act_q == ACT_SET_HASH) begin
										upd_rec.chash  = chash_q;
										upd_rec.lhash  = lhash_q;
										upd_rec.hstate = HS_DONE;
									end else if (act_q == ACT_SET_UNSUP) begin
										upd_rec.hstate = HS_UNSUP;
									end
									wr_en    = (act_q == ACT_SET_HASH) || (act_q == ACT_SET_UNSUP);
									wr_addr  = hit_idx_q;
									wr_rec   = upd_rec;
									emit_rec = upd_rec;
									if (act_q == ACT_UNTRACK) begin
										vclr    = 1'b1;
										cnt_dec = 1'b1;
									end
								end
							end
							ACT_PICK: begin
								if (best_found_q && n_q < limit_q) begin
									// mark learning; show the previous pick, hold this one
									upd_rec        = best_rec_q;
									upd_rec.hstate = HS_LEARNING;
									wr_en     = 1'b1;
									wr_addr   = best_idx_q;
									wr_rec    = upd_rec;
									pick_adv  = 1'b1;
									emit      = held_v_q;
									emit_rec  = held_q;
									emit_last = 1'b0;
									fsm_d     = (n_q + 7'd1 == limit_q) ? FSM_FLUSH : FSM_SCAN;
								end else if (held_v_q) begin
									fsm_d = FSM_FLUSH;
								end else begin
									emit    = 1'b1;
									emit_st = STS_NONE;
								end
							end
							ACT_RESET_HASH: begin
								emit = 1'b1;
							end
							default: begin
								emit    = 1'b1;
								clr_all = 1'b1;
							end
						endcase
					end
				end
			end
			FSM_FLUSH: begin
				if (out_free) begin
					emit     = 1'b1;
					emit_rec = held_q;
					fsm_d    = FSM_IDLE;
				end
			end
			default: fsm_d = FSM_IDLE;
		endcase
	end

	assign scan_start = (fsm_d == FSM_SCAN) && (fsm_q != FSM_SCAN);

	// latch the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= in_act;
			zero_q  <= in_zero;
			key_q   <= in_key;
			width_q <= s_tdata[103:64];
			kind_q  <= s_tdata[105:104];
			frame_q <= s_tdata[137:106];
			chash_q <= s_tdata[169:138];
			lhash_q <= s_tdata[201:170];
			limit_q <= in_limit;
		end
	end

	// valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (clr_all) begin
				valid_q <= '0;
				count_q <= '0;
			end else begin
				if (vclr) valid_q[vclr_idx] <= 1'b0;
				if (vset) valid_q[free_idx_q] <= 1'b1;
				if (cnt_inc) count_q <= count_q + CntW'(1);
				else if (cnt_dec) count_q <= count_q - CntW'(1);
			end
		end
	end

	// read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_done_q <= 1'b1;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
		end else begin
			vld_s1 <= rd_en;
			idx_s1 <= rd_idx_q;
			if (scan_start) begin
				rd_idx_q  <= '0;
				rd_done_q <= 1'b0;
			end else if (rd_en) begin
				if (rd_idx_q == LastIdx) rd_done_q <= 1'b1;
				else rd_idx_q <= rd_idx_q + IdxW'(1);
			end
		end
	end

	// scan trackers: hit, first free, oldest evictable, best pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else if (scan_start || accept) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else if (vld_s1) begin
			if (row_valid && rd_rec.handle == key_q && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_rec_q <= rd_rec;
			end
			if (!row_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (row_valid && (rd_rec.hstate == HS_PENDING || rd_rec.hstate == HS_UNSUP) &&
				(!vic_found_q || rd_rec.frame < vic_frame_q)) begin
				vic_found_q <= 1'b1;
				vic_idx_q   <= idx_s1;
				vic_frame_q <= rd_rec.frame;
			end
			if (row_valid && rd_rec.hstate == HS_PENDING && (!best_found_q ||
				((is_large(rd_rec) != is_large(best_rec_q)) ? is_large(rd_rec) :
				(rd_rec.frame < best_rec_q.frame)))) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_s1;
				best_rec_q   <= rd_rec;
			end
		end
	end

	// pick count and held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q      <= '0;
			held_v_q <= 1'b0;
		end else if (accept) begin
			n_q      <= '0;
			held_v_q <= 1'b0;
		end else if (pick_adv) begin
			n_q      <= n_q + 7'd1;
			held_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pick_adv) begin
			held_q <= upd_rec;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_st_q   <= emit_st;
			out_rec_q  <= emit_rec;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'd0, out_rec_q.count, out_rec_q.frame, out_rec_q.lhash,
		out_rec_q.chash, out_rec_q.hstate, out_rec_q.kind, out_rec_q.width,
		out_rec_q.handle};

	// occupancy tracks the valid bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("occupancy count differs from valid bits");

	// a scan writeback never targets the slot being read
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_idx_q))
		else $error("write and read hit the same slot");

	// picks never exceed the budget
	a_pick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q != FSM_IDLE && act_q == ACT_PICK) |-> (n_q <= limit_q))
		else $error("pick count above budget");

endmodule

`default_nettype wire
